@@ design/bclm_pkg.sv @@
// Shared types and constants for the bicolour LED matrix scan driver.
// Depends on nothing; every other design file imports it.
package bclm_pkg;

  localparam int COLUMNS_DEF = 16;
  localparam int ROWS_DEF    = 16;
  localparam int ROW_SEL_W   = 4;

  localparam logic [1:0] CMD_WRITE   = 2'd0;
  localparam logic [1:0] CMD_CLEAR   = 2'd1;
  localparam logic [1:0] CMD_REFRESH = 2'd2;

  localparam int COLOR_RED_BIT   = 1;
  localparam int COLOR_GREEN_BIT = 0;

  localparam logic KIND_SHIFT = 1'b0;
  localparam logic KIND_LATCH = 1'b1;

  typedef struct packed {
    logic [1:0] cmd;
    logic [3:0] pix_x;
    logic [3:0] pix_y;
    logic [1:0] pix_color;
  } bclm_req_t;

  typedef struct packed {
    logic                 kind;
    logic                 red_out;
    logic                 green_out;
    logic [ROW_SEL_W-1:0] row_select;
    logic                 display_on;
    logic                 last;
  } bclm_res_t;

  typedef struct packed {
    logic write_pix;
    logic clear;
    logic load_row;
    logic shift_col;
    logic latch_row;
  } bclm_cmd_t;

  typedef struct packed {
    logic last_col;
    logic out_free;
  } bclm_status_t;

endpackage

@@ design/bicolor_led_matrix_scan_driver.sv @@
// Bicolour LED matrix row-scan driver: top level joining sequencer and datapath.
// Depends on bclm_pkg, bclm_ctrl and bclm_datapath.
//
// Write-pixel, clear-screen and unknown requests are taken without a stall
// and give no result. A refresh request holds the request side stalled after
// it is taken until its latch result is issued: the column shifter emits one
// active-low red/green bit per cycle while results are not stalled, one per
// column, then one latch result with the row select and display enable, all
// through a single output register, so any result-side stall stretches the run.
// Writes and clears after a refresh has been taken do not disturb its bits.
module bicolor_led_matrix_scan_driver #(
  parameter int COLUMNS = bclm_pkg::COLUMNS_DEF,
  parameter int ROWS    = bclm_pkg::ROWS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  bclm_pkg::bclm_req_t req,
  output logic                res_valid,
  input  logic                res_stall,
  output bclm_pkg::bclm_res_t res
);
  import bclm_pkg::*;

  bclm_cmd_t    cmd;
  bclm_status_t status;

  bclm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_cmd   (req.cmd),
    .req_stall (req_stall),
    .status    (status),
    .cmd       (cmd)
  );

  bclm_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .status    (status),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule

@@ design/bclm_ctrl.sv @@
// Sequencer for the scan driver: decodes requests and steps a refresh run.
// Depends on bclm_pkg; drives bclm_datapath through bclm_cmd_t.
module bclm_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  input  logic [1:0]            req_cmd,
  output logic                  req_stall,
  input  bclm_pkg::bclm_status_t status,
  output bclm_pkg::bclm_cmd_t   cmd
);
  import bclm_pkg::*;

  typedef enum logic [1:0] {IDLE, SHIFT, LATCH} state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      IDLE: begin
        if (req_valid) begin
          unique case (req_cmd)
            CMD_WRITE:   cmd.write_pix = 1'b1;
            CMD_CLEAR:   cmd.clear = 1'b1;
            CMD_REFRESH: begin
              cmd.load_row = 1'b1;
              state_next   = SHIFT;
            end
            default: ;
          endcase
        end
      end
      SHIFT: begin
        if (status.out_free) begin
          cmd.shift_col = 1'b1;
          if (status.last_col) state_next = LATCH;
        end
      end
      LATCH: begin
        if (status.out_free) begin
          cmd.latch_row = 1'b1;
          state_next    = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      req_stall <= 1'b0;
    end else begin
      state     <= state_next;
      req_stall <= (state_next != IDLE);
    end
  end

endmodule

@@ design/bclm_datapath.sv @@
// Frame planes, scan row counter, column shifter and result register.
// Depends on bclm_pkg; commanded by bclm_ctrl.
module bclm_datapath #(
  parameter int COLUMNS = bclm_pkg::COLUMNS_DEF,
  parameter int ROWS    = bclm_pkg::ROWS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  bclm_pkg::bclm_req_t    req,
  input  bclm_pkg::bclm_cmd_t    cmd,
  output bclm_pkg::bclm_status_t status,
  output logic                   res_valid,
  input  logic                   res_stall,
  output bclm_pkg::bclm_res_t    res
);
  import bclm_pkg::*;

  localparam int COL_W = $clog2(COLUMNS);
  localparam int ROW_W = $clog2(ROWS);

  logic [COLUMNS-1:0] red_plane   [ROWS];
  logic [COLUMNS-1:0] green_plane [ROWS];
  logic [ROW_W-1:0]   scan_row;
  logic [COLUMNS-1:0] red_sh;
  logic [COLUMNS-1:0] green_sh;
  logic [COL_W-1:0]   col;

  logic               in_range;
  logic [ROW_W-1:0]   wr_row;
  logic [COLUMNS-1:0] mask;

  assign in_range = (int'(req.pix_x) < COLUMNS) && (int'(req.pix_y) < ROWS);
  assign wr_row   = req.pix_y[ROW_W-1:0];
  assign mask     = COLUMNS'(1) << req.pix_x;

  assign status.last_col = (col == COL_W'(COLUMNS - 1));
  assign status.out_free = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < ROWS; r++) begin
        red_plane[r]   <= '0;
        green_plane[r] <= '0;
      end
      scan_row  <= '0;
      res_valid <= 1'b0;
    end else begin
      if (cmd.clear) begin
        for (int r = 0; r < ROWS; r++) begin
          red_plane[r]   <= '0;
          green_plane[r] <= '0;
        end
      end else if (cmd.write_pix && in_range) begin
        red_plane[wr_row] <= req.pix_color[COLOR_RED_BIT] ?
                             (red_plane[wr_row] | mask) : (red_plane[wr_row] & ~mask);
        green_plane[wr_row] <= req.pix_color[COLOR_GREEN_BIT] ?
                               (green_plane[wr_row] | mask) : (green_plane[wr_row] & ~mask);
      end
      if (cmd.latch_row) begin
        scan_row <= (scan_row == ROW_W'(ROWS - 1)) ? '0 : scan_row + 1'b1;
      end
      if (cmd.shift_col || cmd.latch_row) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_row) begin
      red_sh   <= red_plane[scan_row];
      green_sh <= green_plane[scan_row];
      col      <= '0;
    end else if (cmd.shift_col) begin
      red_sh   <= red_sh >> 1;
      green_sh <= green_sh >> 1;
      col      <= col + 1'b1;
    end
    if (cmd.shift_col) begin
      res.kind       <= KIND_SHIFT;
      res.red_out    <= ~red_sh[0];
      res.green_out  <= ~green_sh[0];
      res.row_select <= '0;
      res.display_on <= 1'b0;
      res.last       <= 1'b0;
    end else if (cmd.latch_row) begin
      res.kind       <= KIND_LATCH;
      res.red_out    <= 1'b0;
      res.green_out  <= 1'b0;
      res.row_select <= ROW_SEL_W'(scan_row);
      res.display_on <= 1'b1;
      res.last       <= 1'b1;
    end
  end

endmodule

@@ design/bclm_checker.sv @@
// Port-level checks for the bicolour LED matrix scan driver.
// Depends on bclm_pkg; bound to the top level below.
module bclm_checker (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_stall,
  input bclm_pkg::bclm_req_t req,
  input logic                res_valid,
  input logic                res_stall,
  input bclm_pkg::bclm_res_t res
);
  import bclm_pkg::*;

  a_reset_quiet: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid straight after reset");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid)
    else $error("stalled result dropped");

  a_latch_form: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.kind == KIND_LATCH) |-> res.last && res.display_on)
    else $error("latch result without last or display enable");

  a_shift_form: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.kind == KIND_SHIFT) |->
      !res.display_on && !res.last && (res.row_select == '0))
    else $error("shift result with latch fields set");

  a_refresh_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && (req.cmd == CMD_REFRESH) |=> req_stall)
    else $error("new request taken during a refresh run");

endmodule

bind bicolor_led_matrix_scan_driver bclm_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req       (req),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res)
);

@@ dv/bicolor_led_matrix_scan_driver_test.sv @@
// Self-checking test for the bicolour LED matrix scan driver: pixel writes, clears
// and row refreshes are checked against a frame-plane scoreboard kept in the bench.
// Depends on bclm_pkg and bicolor_led_matrix_scan_driver.
`timescale 1ns / 100ps

module bicolor_led_matrix_scan_driver_test;
  import bclm_pkg::*;

  localparam int         COLS        = COLUMNS_DEF;
  localparam int         NROWS       = ROWS_DEF;
  localparam logic [1:0] CMD_UNUSED  = 2'd3;
  localparam int         RAND_ITEMS  = 140;
  localparam int         HOLD_OFF    = 400;
  localparam int         IDLE_LIMIT  = 2000;
  localparam int         DRAIN_WAIT  = 60;

  class frame_scoreboard;
    logic [COLS-1:0]  red_rows[NROWS];
    logic [COLS-1:0]  green_rows[NROWS];
    logic [3:0]       scan_row;
    bclm_res_t        pending_scan[$];
    int               errors;

    function new();
      clear_planes();
      scan_row = '0;
      errors   = 0;
    endfunction

    function void clear_planes();
      foreach (red_rows[i]) begin
        red_rows[i]   = '0;
        green_rows[i] = '0;
      end
    endfunction

    function void note_request(bclm_req_t r);
      bclm_res_t e;
      case (r.cmd)
        CMD_WRITE: begin
          if (r.pix_x < COLS && r.pix_y < NROWS) begin
            red_rows[r.pix_y][r.pix_x]   = r.pix_color[COLOR_RED_BIT];
            green_rows[r.pix_y][r.pix_x] = r.pix_color[COLOR_GREEN_BIT];
          end
        end
        CMD_CLEAR: clear_planes();
        CMD_REFRESH: begin
          for (int c = 0; c < COLS; c++) begin
            e           = '0;
            e.kind      = KIND_SHIFT;
            e.red_out   = ~red_rows[scan_row][c];
            e.green_out = ~green_rows[scan_row][c];
            pending_scan.push_back(e);
          end
          e            = '0;
          e.kind       = KIND_LATCH;
          e.row_select = scan_row;
          e.display_on = 1'b1;
          e.last       = 1'b1;
          pending_scan.push_back(e);
          scan_row = (scan_row == NROWS - 1) ? '0 : scan_row + 4'd1;
        end
        default: ;
      endcase
    endfunction

    function void check_result(bclm_res_t a);
      bclm_res_t e;
      if (pending_scan.size() == 0) begin
        $error("unexpected result %b with nothing pending", a);
        errors++;
        return;
      end
      e = pending_scan.pop_front();
      if (a.kind !== e.kind) begin
        $error("kind: expected %0d, got %0d", e.kind, a.kind);
        errors++;
      end
      if (a.red_out !== e.red_out) begin
        $error("red_out: expected %0d, got %0d", e.red_out, a.red_out);
        errors++;
      end
      if (a.green_out !== e.green_out) begin
        $error("green_out: expected %0d, got %0d", e.green_out, a.green_out);
        errors++;
      end
      if (a.row_select !== e.row_select) begin
        $error("row_select: expected %0d, got %0d", e.row_select, a.row_select);
        errors++;
      end
      if (a.display_on !== e.display_on) begin
        $error("display_on: expected %0d, got %0d", e.display_on, a.display_on);
        errors++;
      end
      if (a.last !== e.last) begin
        $error("last: expected %0d, got %0d", e.last, a.last);
        errors++;
      end
    endfunction

    function int pending();
      return pending_scan.size();
    endfunction
  endclass

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_stall;
  bclm_req_t req       = '0;
  logic      res_valid;
  logic      res_stall = 1'b0;
  bclm_res_t res;

  frame_scoreboard sb = new();
  int              sent = 0;
  int              idle_cycles = 0;

  bicolor_led_matrix_scan_driver u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) sb.check_result(res);
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (res_valid && !res_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic bclm_req_t pack_req(logic [1:0] cmd, logic [3:0] x, logic [3:0] y,
                                         logic [1:0] color);
    bclm_req_t r;
    r.cmd       = cmd;
    r.pix_x     = x;
    r.pix_y     = y;
    r.pix_color = color;
    return r;
  endfunction

  task automatic send_req(input bclm_req_t r);
    int gap;
    gap = (sent >= 60 && sent < 90) ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (req_stall);
    sb.note_request(r);
    sent++;
  endtask

  task automatic take_results();
    int  n;
    int  taken;
    bit  held;
    taken = 0;
    held  = 1'b0;
    forever begin
      if (!held && taken >= 200) begin
        held = 1'b1;
        n    = HOLD_OFF;
      end else begin
        n = ((taken / 50) % 4 == 1) ? 0 : $urandom_range(0, 10);
      end
      if (n > 0) begin
        res_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      res_stall <= 1'b0;
      do @(posedge clk); while (!res_valid);
      taken++;
    end
  endtask

  task automatic send_random();
    int        pick;
    int        counted;
    bclm_req_t r;
    counted = 0;
    while (counted < RAND_ITEMS) begin
      pick = $urandom_range(0, 99);
      r    = pack_req(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                      4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)));
      if (pick < 62) begin
        r.cmd = CMD_WRITE;
        if ($urandom_range(0, 1)) r.pix_y = sb.scan_row;
      end else if (pick < 66) begin
        r.cmd = CMD_CLEAR;
      end else if (pick < 68) begin
        r.cmd = CMD_UNUSED;
      end else begin
        r.cmd = CMD_REFRESH;
      end
      send_req(r);
      if (r.cmd != CMD_UNUSED) counted++;
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    fork
      take_results();
    join_none

    send_req(pack_req(CMD_REFRESH, 4'd9, 4'd3, 2'd1));
    send_req(pack_req(CMD_WRITE, 4'd0, 4'd1, 2'd3));
    send_req(pack_req(CMD_WRITE, 4'd15, 4'd1, 2'd2));
    send_req(pack_req(CMD_WRITE, 4'd7, 4'd1, 2'd1));
    send_req(pack_req(CMD_WRITE, 4'd8, 4'd1, 2'd3));
    send_req(pack_req(CMD_WRITE, 4'd8, 4'd1, 2'd0));
    send_req(pack_req(CMD_REFRESH, 4'd15, 4'd15, 2'd3));
    send_req(pack_req(CMD_WRITE, 4'd0, 4'd2, 2'd3));
    send_req(pack_req(CMD_WRITE, 4'd15, 4'd2, 2'd3));
    send_req(pack_req(CMD_CLEAR, 4'd15, 4'd15, 2'd3));
    send_req(pack_req(CMD_REFRESH, 4'd0, 4'd0, 2'd0));
    send_req(pack_req(CMD_UNUSED, 4'd15, 4'd3, 2'd3));
    send_req(pack_req(CMD_UNUSED, 4'd0, 4'd3, 2'd0));
    send_req(pack_req(CMD_REFRESH, 4'd0, 4'd0, 2'd0));
    send_req(pack_req(CMD_WRITE, 4'd15, 4'd4, 2'd3));
    send_req(pack_req(CMD_WRITE, 4'd0, 4'd4, 2'd1));
    send_req(pack_req(CMD_WRITE, 4'd3, 4'd4, 2'd2));
    send_req(pack_req(CMD_WRITE, 4'd15, 4'd15, 2'd3));
    send_req(pack_req(CMD_WRITE, 4'd0, 4'd15, 2'd2));
    send_req(pack_req(CMD_REFRESH, 4'd5, 4'd10, 2'd2));
    send_req(pack_req(CMD_REFRESH, 4'd10, 4'd5, 2'd1));

    send_random();
    req_valid <= 1'b0;

    while (sb.pending() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
